// File: rtl/rmmt_pkg.sv
// Package with the constants, widths and state type of the running median and mean tracker.
package rmmt_pkg;

  // Number of samples the sorted store can hold.
  localparam int CAPACITY = 128;
  // Number of low sample bits that take part in the statistics.
  localparam int SAMPLE_BITS = 16;

  // Fixed widths of the request and result fields.
  localparam int SAMPLE_FIELD_W = 16;
  localparam int COUNT_FIELD_W  = 8;
  localparam int MEDIAN_FIELD_W = 16;
  localparam int MEAN_FIELD_W   = 16;

  // Derived datapath widths.
  localparam int DATA_W    = (SAMPLE_BITS < SAMPLE_FIELD_W) ? SAMPLE_BITS : SAMPLE_FIELD_W;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int SUM_W     = DATA_W + $clog2(CAPACITY);
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_START,
    ST_INS_STEP,
    ST_INS_HEAD,
    ST_MED_RD,
    ST_MED_HI,
    ST_MED_LO,
    ST_DIV,
    ST_DONE
  } rmmt_state_e;

endpackage

// File: rtl/rmmt_stream_if.sv
// Handshake interfaces for the sample requests and the statistics results.
interface rmmt_in_if import rmmt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [SAMPLE_FIELD_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rmmt_out_if import rmmt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [COUNT_FIELD_W-1:0]  held_count;
  logic [MEDIAN_FIELD_W-1:0] median;
  logic [MEAN_FIELD_W-1:0]   mean;
  logic                      full_res;

  modport source (output valid, output held_count, output median, output mean,
                  output full_res, input ready);
  modport sink (input valid, input held_count, input median, input mean,
                input full_res, output ready);
endinterface

// File: rtl/running_median_mean_tracker.sv
// Running median and mean tracker: keeps up to CAPACITY samples in a sorted RAM and a running
// sum, and answers every sample request with one result carrying the held count, the median,
// the truncated mean and a full flag. A request is taken only while the block is idle; the
// previous result may still be waiting in the output register. From one accepted request to
// the next one the block can take, it starts the insertion, walks the store, moving each of
// the k stored entries greater than the new sample (0 to CAPACITY-1) up one place, reads the
// median (one entry for an odd count, two for an even count), runs the division, loads the
// output register once an earlier result has left it, and returns to idle. The walk is
// skipped for the first sample and for a rejected one. The insertion walk is bound by the
// single read and single write port of the store RAM, one entry per cycle. The mean comes
// from a radix-2 restoring divider that produces one quotient bit per cycle over the
// SUM_W-bit running sum. Once the store is full, a request is rejected without changing the
// state and answers after the median and divide phases alone. The sorted store needs no
// clearing after reset, since entries are read only after they have been written.
module running_median_mean_tracker import rmmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rmmt_in_if.sink     in_i,
  rmmt_out_if.source  out_o
);

  // Sequencer state and bookkeeping.
  rmmt_state_e state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [SUM_W-1:0]     sum_q, sum_d;

  // Per-request working registers.
  logic [DATA_W-1:0]    val_q, val_d;
  logic [ADDR_W-1:0]    idx_q, idx_d;
  logic                 full_q, full_d;
  logic [DATA_W-1:0]    hi_q, hi_d;
  logic [DATA_W-1:0]    med_q, med_d;

  // Restoring divider registers.
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [SUM_W-1:0]     quo_q, quo_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  // Output register.
  logic                      out_valid_q, out_valid_d;
  logic [COUNT_FIELD_W-1:0]  out_count_q, out_count_d;
  logic [MEDIAN_FIELD_W-1:0] out_med_q, out_med_d;
  logic [MEAN_FIELD_W-1:0]   out_mean_q, out_mean_d;
  logic                      out_full_q, out_full_d;

  // Store RAM port signals.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Derived values.
  logic              in_take;
  logic              store_full;
  logic              rd_greater;
  logic [CNT_W-1:0]  mid;
  logic              count_even;
  logic [CNT_W:0]    div_partial;
  logic [CNT_W:0]    div_diff;
  logic              div_fits;
  logic [DATA_W:0]   med_pair_sum;
  logic              out_load;

  rmmt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_take      = in_i.valid && in_i.ready;
  assign store_full   = (count_q == CNT_W'(CAPACITY));
  // Strictly greater, so a new sample lands after stored entries of equal value.
  assign rd_greater   = (ram_rdata > val_q);
  assign mid          = count_q >> 1;
  assign count_even   = ~count_q[0];
  assign div_partial  = {rem_q, quo_q[SUM_W-1]};
  assign div_diff     = div_partial - {1'b0, count_q};
  assign div_fits     = (div_partial >= {1'b0, count_q});
  assign med_pair_sum = {1'b0, hi_q} + {1'b0, ram_rdata};
  assign out_load     = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = ST_INS_START;
        end
      end
      ST_INS_START: begin
        if (store_full || count_q == '0) begin
          state_d = ST_MED_RD;
        end else begin
          state_d = ST_INS_STEP;
        end
      end
      ST_INS_STEP: begin
        if (!rd_greater) begin
          state_d = ST_MED_RD;
        end else if (idx_q == ADDR_W'(1)) begin
          state_d = ST_INS_HEAD;
        end
      end
      ST_INS_HEAD: state_d = ST_MED_RD;
      ST_MED_RD:   state_d = ST_MED_HI;
      ST_MED_HI: begin
        state_d = count_even ? ST_MED_LO : ST_DIV;
      end
      ST_MED_LO:   state_d = ST_DIV;
      ST_DIV: begin
        if (div_cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output logic: request handshake and store RAM accesses.
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = val_q;
    ram_re     = 1'b0;
    ram_raddr  = ADDR_W'(mid);
    unique case (state_q)
      ST_INS_START: begin
        if (!store_full) begin
          if (count_q == '0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(count_q - CNT_W'(1));
          end
        end
      end
      ST_INS_STEP: begin
        // Each step moves a larger entry up one place or drops the sample into the gap.
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = rd_greater ? ram_rdata : val_q;
        if (rd_greater && idx_q != ADDR_W'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q - ADDR_W'(2);
        end
      end
      ST_INS_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
      end
      ST_MED_RD: begin
        ram_re = 1'b1;
      end
      ST_MED_HI: begin
        if (count_even) begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(mid - CNT_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    count_d     = count_q;
    sum_d       = sum_q;
    val_d       = val_q;
    idx_d       = idx_q;
    full_d      = full_q;
    hi_d        = hi_q;
    med_d       = med_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_cnt_d   = div_cnt_q;
    out_count_d = out_count_q;
    out_med_d   = out_med_q;
    out_mean_d  = out_mean_q;
    out_full_d  = out_full_q;
    out_valid_d = out_valid_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          val_d = in_i.sample[DATA_W-1:0];
        end
      end
      ST_INS_START: begin
        full_d = store_full;
        idx_d  = ADDR_W'(count_q);
        if (!store_full) begin
          count_d = count_q + CNT_W'(1);
          sum_d   = sum_q + SUM_W'(val_q);
        end
      end
      ST_INS_STEP: begin
        idx_d = idx_q - ADDR_W'(1);
      end
      ST_MED_RD: begin
        rem_d     = '0;
        quo_d     = sum_q;
        div_cnt_d = DIV_CNT_W'(SUM_W - 1);
      end
      ST_MED_HI: begin
        hi_d  = ram_rdata;
        med_d = ram_rdata;
      end
      ST_MED_LO: begin
        med_d = med_pair_sum[DATA_W:1];
      end
      ST_DIV: begin
        quo_d     = {quo_q[SUM_W-2:0], div_fits};
        rem_d     = div_fits ? div_diff[CNT_W-1:0] : div_partial[CNT_W-1:0];
        div_cnt_d = div_cnt_q - DIV_CNT_W'(1);
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_count_d = COUNT_FIELD_W'(count_q);
          out_med_d   = MEDIAN_FIELD_W'(med_q);
          out_mean_d  = MEAN_FIELD_W'(quo_q);
          out_full_d  = full_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    idx_q       <= idx_d;
    full_q      <= full_d;
    hi_q        <= hi_d;
    med_q       <= med_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    div_cnt_q   <= div_cnt_d;
    out_count_q <= out_count_d;
    out_med_q   <= out_med_d;
    out_mean_q  <= out_mean_d;
    out_full_q  <= out_full_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.held_count = out_count_q;
  assign out_o.median     = out_med_q;
  assign out_o.mean       = out_mean_q;
  assign out_o.full_res   = out_full_q;

endmodule

// File: rtl/rmmt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rmmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: verif/running_median_mean_tracker_tb.sv
// Self-checking testbench for the running median and mean tracker.
`timescale 1ns / 100ps

module running_median_mean_tracker_tb;
  import rmmt_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 10;
  // Length of the drain wait at the end. A result can sit a while in the output register.
  localparam int DRAIN_CYCLES  = 200;
  // Requests sent after the store has filled up, to exercise the rejection path.
  localparam int FULL_REQUESTS = 272;
  // Long receiver hold-off that makes the block fill up and stall its input.
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int HOLD_OFF_AFTER  = 40;
  // About 400 requests, each with its worst-case work, the longest sender gap
  // and the longest receiver stall, plus the long hold-off: roughly 2.7 ms.
  // The limit below is several times that.
  localparam longint TIME_LIMIT_NS = 20_000_000;

  // One result as the block reports it.
  typedef struct packed {
    logic [COUNT_FIELD_W-1:0]  held_count;
    logic [MEDIAN_FIELD_W-1:0] median;
    logic [MEAN_FIELD_W-1:0]   mean;
    logic                      full_res;
  } stats_t;

  // One row of the directed table. Where typed is set, the expected result is
  // written out by hand; otherwise the predictor supplies it.
  typedef struct {
    logic [SAMPLE_FIELD_W-1:0] sample;
    bit                        typed;
    stats_t                    want;
  } directed_row_t;

  localparam int N_DIRECTED = 18;

  logic clk_i = 1'b0;
  logic rst_ni;

  rmmt_in_if  sample_if ();
  rmmt_out_if stats_if ();

  running_median_mean_tracker i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sample_if),
    .out_o  (stats_if)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // The directed part starts right after reset. The first two rows can be
  // worked out by hand: a single zero sample, then zero and full scale, whose
  // median and mean are both half of full scale, truncated. The rest covers
  // duplicates at both ends, samples that walk the whole store, alternating bit
  // patterns and values in between.
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{16'h0000, 1'b1, '{8'd1, 16'd0, 16'd0, 1'b0}},
    '{16'hFFFF, 1'b1, '{8'd2, 16'd32767, 16'd32767, 1'b0}},
    '{16'hFFFF, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'h8000, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'h0001, 1'b0, '0},
    '{16'hFFFE, 1'b0, '0},
    '{16'h5555, 1'b0, '0},
    '{16'hAAAA, 1'b0, '0},
    '{16'h0000, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'h00FF, 1'b0, '0},
    '{16'hFF00, 1'b0, '0},
    '{16'h0F0F, 1'b0, '0},
    '{16'hF0F0, 1'b0, '0},
    '{16'h0002, 1'b0, '0},
    '{16'h1234, 1'b0, '0}
  };

  // The predictor's own copy of the tracker state.
  logic [DATA_W-1:0] sorted_copy [CAPACITY];
  int unsigned       held_n;
  longint unsigned   sum_acc;

  // Results still owed by the block, oldest first.
  stats_t pending_stats_q [$];

  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned full_sent;
  int unsigned hold_off_left;
  bit          pressure_done;
  bit          sender_calm;
  bit          receiver_calm;

  // Applies one sample to the predicted state and returns the statistics that
  // the block should report for it. A sample is inserted by shifting every
  // larger entry up by one, which leaves the store in the same order as the
  // block's backward shift-and-insert pass. Once the store holds CAPACITY
  // samples, the sample is rejected and only the full flag changes.
  function automatic stats_t track_sample(logic [SAMPLE_FIELD_W-1:0] sample);
    stats_t            r;
    logic [DATA_W-1:0] v;
    int unsigned       pos;
    int unsigned       mid;
    v = sample[DATA_W-1:0];
    r.full_res = (held_n >= CAPACITY);
    if (!r.full_res) begin
      pos = held_n;
      while (pos > 0 && sorted_copy[pos-1] > v) begin
        sorted_copy[pos] = sorted_copy[pos-1];
        pos--;
      end
      sorted_copy[pos] = v;
      sum_acc += v;
      held_n++;
    end
    // With CAPACITY of at least two, the count is never zero here.
    mid = held_n / 2;
    r.held_count = COUNT_FIELD_W'(held_n);
    if (held_n % 2 != 0) begin
      r.median = MEDIAN_FIELD_W'(sorted_copy[mid]);
    end else begin
      r.median = MEDIAN_FIELD_W'(((DATA_W+1)'(sorted_copy[mid-1]) +
                                  (DATA_W+1)'(sorted_copy[mid])) >> 1);
    end
    r.mean = MEAN_FIELD_W'(sum_acc / held_n);
    return r;
  endfunction

  // Random samples: mostly full range, with a share of small values, both
  // extremes, values near the top, and repeats of values already held so that
  // ties in the sorted store come up often.
  function automatic logic [SAMPLE_FIELD_W-1:0] random_sample();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return SAMPLE_FIELD_W'($urandom);
    if (roll < 75) return SAMPLE_FIELD_W'($urandom_range(0, 15));
    if (roll < 85) begin
      return ($urandom_range(0, 1) != 0) ? {SAMPLE_FIELD_W{1'b1}} : {SAMPLE_FIELD_W{1'b0}};
    end
    if (held_n != 0 && held_n <= CAPACITY) begin
      return SAMPLE_FIELD_W'(sorted_copy[$urandom_range(0, held_n - 1)]);
    end
    return SAMPLE_FIELD_W'($urandom_range(65520, 65535));
  endfunction

  // Idle cycles before the next request. The sender switches now and then
  // between a calm mode with back-to-back requests and a choppy one where most
  // gaps are short and a few are long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    if (sender_calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 300);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Offers one sample request and holds it until the block takes it. The
  // expected result is queued at the edge where the handshake completes. Valid
  // is only lowered when a gap follows, so it never gets two updates in one
  // time step.
  task automatic send_sample(logic [SAMPLE_FIELD_W-1:0] sample, bit typed, stats_t want);
    stats_t      predicted;
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid  <= 1'b1;
    sample_if.sample <= sample;
    do @(posedge clk_i); while (sample_if.ready !== 1'b1);
    // The predictor always runs so that its state follows the block, even when
    // the table supplies the expected result.
    predicted = track_sample(sample);
    pending_stats_q.push_back(typed ? want : predicted);
  endtask

  // Compares one result with the oldest expectation, field by field.
  task automatic check_stats(stats_t got);
    stats_t want;
    if (pending_stats_q.size() == 0) begin
      report_mismatch("result with no request pending, held_count", got.held_count, 0);
      return;
    end
    want = pending_stats_q.pop_front();
    if (got.held_count !== want.held_count) begin
      report_mismatch("held_count", got.held_count, want.held_count);
    end
    if (got.median !== want.median) report_mismatch("median", got.median, want.median);
    if (got.mean !== want.mean) report_mismatch("mean", got.mean, want.mean);
    if (got.full_res !== want.full_res) report_mismatch("full_res", got.full_res, want.full_res);
  endtask

  // Stimulus and end of run.
  initial begin
    rst_ni           = 1'b0;
    sample_if.valid  = 1'b0;
    sample_if.sample = '0;
    held_n           = 0;
    sum_acc          = 0;
    mismatches       = 0;
    full_sent        = 0;
    sender_calm      = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random requests fill the store to capacity; after that, a batch of
    // requests checks that a full store rejects samples and keeps its state.
    while (held_n < CAPACITY || full_sent < FULL_REQUESTS) begin
      if (held_n >= CAPACITY) full_sent++;
      send_sample(random_sample(), 1'b0, '0);
    end
    sample_if.valid <= 1'b0;

    while (pending_stats_q.size() != 0) @(posedge clk_i);
    // A few more cycles so that a spurious extra result would still be seen.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side. Each cycle it checks a completed handshake, then decides the
  // ready level for the next cycle. Once HOLD_OFF_AFTER results have been
  // checked, it holds ready low for a long stretch while the sender keeps
  // offering requests, so the block fills its output register and stalls.
  initial begin
    stats_if.ready  = 1'b0;
    results_checked = 0;
    hold_off_left   = 0;
    pressure_done   = 1'b0;
    receiver_calm   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stats_if.valid === 1'b1 && stats_if.ready === 1'b1) begin
        check_stats('{stats_if.held_count, stats_if.median, stats_if.mean, stats_if.full_res});
        results_checked++;
        if (!pressure_done && results_checked == HOLD_OFF_AFTER) begin
          hold_off_left = HOLD_OFF_CYCLES;
          pressure_done = 1'b1;
        end
      end
      if (hold_off_left != 0) begin
        hold_off_left--;
        stats_if.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 199) == 0) receiver_calm = !receiver_calm;
        if (receiver_calm) begin
          stats_if.ready <= 1'b1;
        end else begin
          case ($urandom_range(0, 999)) inside
            [0:599]:   stats_if.ready <= 1'b1;
            [600:989]: stats_if.ready <= 1'b0;
            default: begin
              // An occasional long stall, counted down above.
              hold_off_left = $urandom_range(20, 200);
              stats_if.ready <= 1'b0;
            end
          endcase
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(TIME_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
